/* sv/teq_pkg.sv */
`timescale 1ns / 1ps
package teq_pkg;
   localparam int unsigned DefQueueDepth = 16;
   localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
   localparam logic [31:0] STALE_WINDOW = 32'h1000_0000;
   localparam logic [2:0] OP_INS_DELAY = 3'd0;
   localparam logic [2:0] OP_INS_AT    = 3'd1;
   localparam logic [2:0] OP_POP       = 3'd2;
   localparam logic [2:0] OP_REMOVE    = 3'd3;
   localparam logic [2:0] OP_FIND      = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [11:0] event_type;
      logic [31:0] time_value;
      logic [31:0] current_count;
   } op_type;

   typedef struct packed {
      logic        head_valid;
      logic [11:0] head_type;
      logic [31:0] head_time;
      logic [31:0] next_event_time;
      logic [11:0] popped_type;
      logic        found;
      logic [31:0] found_time;
      logic        overflow;
      logic [4:0]  occupancy;
   } res_type;
endpackage

/* sv/teq_front.sv */
`timescale 1ns / 1ps
module teq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  teq_pkg::op_type   in_op,
   output logic              q_valid,
   input  logic              q_ready,
   output teq_pkg::op_type   q_op
);
   import teq_pkg::*;
   // two-entry queue; resolves insert-after-delay into absolute time
   op_type     buf_ff [2];
   op_type     buf_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_op     = buf_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      buf_in = in_op;
      if (in_op.opcode == OP_INS_DELAY) begin
         buf_in.opcode     = OP_INS_AT;
         buf_in.time_value = in_op.current_count + in_op.time_value;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) buf_ff[wr_ff] <= buf_in;
   end
endmodule

/* sv/teq_back.sv */
`timescale 1ns / 1ps
module teq_back #(
   parameter int unsigned QUEUE_DEPTH = teq_pkg::DefQueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [11:0]       special_code,
   input  logic              q_valid,
   output logic              q_ready,
   input  teq_pkg::op_type   q_op,
   output logic              out_valid,
   input  logic              out_ready,
   output teq_pkg::res_type  out_res
);
   import teq_pkg::*;
   localparam int unsigned IW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [1:0] ST_IDLE = 2'd0, ST_EXEC = 2'd1, ST_OUT = 2'd2;

   logic [11:0] ty_ff [QUEUE_DEPTH];
   logic [31:0] tm_ff [QUEUE_DEPTH];
   logic [11:0] ty_in [QUEUE_DEPTH];
   logic [31:0] tm_in [QUEUE_DEPTH];
   logic [CW-1:0] fill_ff, fill_in;
   logic        sdone_ff, sdone_in;
   logic [31:0] due_ff, due_in;
   logic [1:0]  st_ff, st_in;
   op_type      op_ff, op_in;
   res_type     res_ff, res_in;
   res_type     res_view;
   // per-slot flags, evaluated against the operation being taken in
   logic [QUEUE_DEPTH-1:0] bef_ff, bef_in, eq_ff, eq_in, hit_ff, hit_in;

   always_comb begin
      logic [31:0] dt, de, ago;
      logic        sd;
      dt = q_op.time_value - q_op.current_count;
      // an insert drops the special-done flag before ordering when past half range
      sd = sdone_ff && !(q_op.current_count > HALF_RANGE);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         de  = tm_ff[i] - q_op.current_count;
         ago = q_op.current_count - tm_ff[i];
         if (dt >= HALF_RANGE)       bef_in[i] = 1'b0;
         else if (de < HALF_RANGE)   bef_in[i] = dt < de;
         else if (ago < STALE_WINDOW)
            bef_in[i] = (ty_ff[i] == special_code) && sd;
         else                        bef_in[i] = 1'b1;
         eq_in[i]  = tm_ff[i] == q_op.time_value;
         hit_in[i] = ty_ff[i] == q_op.event_type;
      end
   end

   assign q_ready   = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_OUT);
   assign out_res   = res_view;

   always_comb begin
      logic            spec, done, ins, rem, any;
      logic [CW-1:0]   pos, idx;
      logic [31:0]     nh;
      st_in = st_ff; op_in = op_ff; res_in = res_ff;
      fill_in = fill_ff; sdone_in = sdone_ff; due_in = due_ff;
      ty_in = ty_ff; tm_in = tm_ff;
      spec = 1'b0; done = 1'b0; ins = 1'b0; rem = 1'b0; any = 1'b0;
      pos = '0; idx = '0; nh = '0;
      unique case (st_ff)
         ST_IDLE: if (q_valid) begin
            op_in = q_op;
            st_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_in.popped_type = '0;
            res_in.found       = 1'b0;
            res_in.found_time  = '0;
            res_in.overflow    = 1'b0;
            spec = op_ff.event_type == special_code;
            case (op_ff.opcode)
               OP_INS_AT: begin
                  if (op_ff.current_count > HALF_RANGE) sdone_in = 1'b0;
                  if (fill_ff == CW'(QUEUE_DEPTH)) res_in.overflow = 1'b1;
                  else begin
                     ins = 1'b1;
                     if (fill_ff == '0 || (!spec && bef_ff[0])) begin
                        pos = '0;
                        due_in = op_ff.time_value;
                     end else begin
                        // walk past entries not preceded, then equal times
                        pos = CW'(1);
                        done = 1'b0;
                        for (int i = 1; i < QUEUE_DEPTH; i++)
                           if (!done && CW'(i) < fill_ff) begin
                              if (spec || !bef_ff[i]) pos = CW'(i + 1);
                              else done = 1'b1;
                           end
                        done = spec;
                        for (int i = 1; i < QUEUE_DEPTH; i++)
                           if (!done && CW'(i) == pos && pos < fill_ff) begin
                              if (eq_ff[i]) pos = CW'(i + 1);
                              else done = 1'b1;
                           end
                     end
                  end
               end
               OP_POP: if (fill_ff != '0) begin
                  res_in.popped_type = ty_ff[0];
                  if (ty_ff[0] == special_code) sdone_in = 1'b1;
                  rem = 1'b1; idx = '0;
                  nh = tm_ff[1 % QUEUE_DEPTH];
                  if (fill_ff > CW'(1) && (nh > op_ff.current_count ||
                      (op_ff.current_count - nh) < HALF_RANGE))
                     due_in = nh;
                  else due_in = '0;
               end
               OP_REMOVE, OP_FIND: begin
                  for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                     if (hit_ff[i] && CW'(i) < fill_ff) begin
                        any = 1'b1; idx = CW'(i);
                     end
                  if (any) begin
                     res_in.found = 1'b1;
                     res_in.found_time = tm_ff[idx[IW-1:0]];
                     rem = op_ff.opcode == OP_REMOVE;
                  end
               end
               default: ;
            endcase
            if (ins) begin
               for (int i = 1; i < QUEUE_DEPTH; i++)
                  if (CW'(i) > pos) begin
                     ty_in[i] = ty_ff[i-1]; tm_in[i] = tm_ff[i-1];
                  end
               ty_in[pos[IW-1:0]] = op_ff.event_type;
               tm_in[pos[IW-1:0]] = op_ff.time_value;
               fill_in = fill_ff + CW'(1);
            end
            if (rem) begin
               for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                  if (CW'(i) >= idx) begin
                     ty_in[i] = ty_ff[i+1]; tm_in[i] = tm_ff[i+1];
                  end
               fill_in = fill_ff - CW'(1);
            end
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // head fields follow the committed state in the output state
   always_comb begin
      res_view = res_ff;
      res_view.head_valid      = fill_ff != '0;
      res_view.head_type       = (fill_ff != '0) ? ty_ff[0] : '0;
      res_view.head_time       = (fill_ff != '0) ? tm_ff[0] : '0;
      res_view.next_event_time = due_ff;
      res_view.occupancy       = 5'(fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         fill_ff  <= '0;
         sdone_ff <= 1'b0;
         due_ff   <= '0;
      end else begin
         st_ff    <= st_in;
         fill_ff  <= fill_in;
         sdone_ff <= sdone_in;
         due_ff   <= due_in;
      end
      op_ff  <= op_in;
      res_ff <= (st_ff == ST_OUT) ? res_ff : res_in;
      bef_ff <= bef_in;
      eq_ff  <= eq_in;
      hit_ff <= hit_in;
      ty_ff  <= ty_in;
      tm_ff  <= tm_in;
   end
endmodule

/* sv/timed_event_queue_wrap_order_top.sv */
`timescale 1ns / 1ps
// Timed event queue kept in wraparound order against a free-running count.
// req_ channel: one operation per transaction (insert after delay, insert
// at time, pop, remove type, find type). rsp_ channel: one result per
// operation with the head, next-event time, find/pop data and occupancy.
// csr_wen/csr_wdata write the special (rollover-guard) type code.
// A front stage turns a delay into an absolute time and holds up to two
// operations; the back engine takes one at a time: it latches the operation
// in the idle state while all slot compares run in parallel, does the shift
// and result in the execute state, then presents the result in the output
// state until it is taken, and only then accepts the next operation.
// Reset empties the queue, clears the special-done flag and next time,
// and sets the type code to 32. A stalled rsp_ holds the result and the
// engine; the front keeps accepting until its two entries are full.
module timed_event_queue_wrap_order_top #(
   parameter int unsigned QUEUE_DEPTH = teq_pkg::DefQueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [11:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], event_type[14:3], time_value[46:15], current_count[78:47]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // head_valid[0], head_type[12:1], head_time[44:13], next_event_time[76:45],
   // popped_type[88:77], found[89], found_time[121:90], overflow[122],
   // occupancy[127:123]
   output logic [127:0] rsp_tdata
);
   import teq_pkg::*;
   logic [11:0] code_ff;
   op_type  in_op, q_op;
   res_type res;
   logic    q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) code_ff <= 12'd32;
      else if (csr_wen) code_ff <= csr_wdata;
   end

   assign in_op.opcode        = req_tdata[2:0];
   assign in_op.event_type    = req_tdata[14:3];
   assign in_op.time_value    = req_tdata[46:15];
   assign in_op.current_count = req_tdata[78:47];

   teq_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_op,
      .q_valid, .q_ready, .q_op
   );

   teq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .special_code(code_ff), .q_valid, .q_ready, .q_op,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {res.occupancy, res.overflow, res.found_time, res.found,
                       res.popped_type, res.next_event_time, res.head_time,
                       res.head_type, res.head_valid};

   a_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> res.occupancy <= 5'(QUEUE_DEPTH)) else $error("occupancy");
   a_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res.head_valid == (res.occupancy != '0))) else $error("head");
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.overflow |-> !res.found) else $error("ovf");
endmodule

/* tb/tb_timed_event_queue_wrap_order_top.sv */
`timescale 1ns / 1ps
module tb_timed_event_queue_wrap_order_top;
   import teq_pkg::*;

   localparam int unsigned DEPTH = DefQueueDepth;
   localparam int unsigned STALL_LIMIT = 5000;

   typedef struct {
      logic [2:0]  opcode;
      logic [11:0] event_type;
      logic [31:0] time_value;
      logic [31:0] current_count;
   } queue_op_t;

   typedef struct {
      logic        head_valid;
      logic [11:0] head_type;
      logic [31:0] head_time;
      logic [31:0] next_event_time;
      logic [11:0] popped_type;
      logic        found;
      logic [31:0] found_time;
      logic        overflow;
      logic [4:0]  occupancy;
   } queue_status_t;

   logic         clock;
   logic         reset;
   logic         csr_wen;
   logic [11:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;

   timed_event_queue_wrap_order_top u_top (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // shadow of the event queue
   logic [11:0] sh_type[DEPTH];
   logic [31:0] sh_time[DEPTH];
   int unsigned sh_fill;
   logic        sh_special_done;
   logic [31:0] sh_next_due;
   logic [11:0] sh_special_code;

   queue_op_t     pending_ops[$];
   queue_status_t expected_status[$];
   bit            failed;
   bit            quiet_mode;
   bit            drain_request;
   int            send_gap;
   int            recv_gap;
   int unsigned   idle_cycles;
   bit            timed_out;

   function automatic bit precedes(logic [31:0] t, logic [31:0] e, logic [11:0] ty,
                                   logic [31:0] cnt);
      logic [31:0] dt;
      logic [31:0] de;
      logic [31:0] ago;
      dt = t - cnt;
      de = e - cnt;
      ago = cnt - e;
      if (dt >= HALF_RANGE) return 0;
      if (de < HALF_RANGE) return dt < de;
      if (ago < STALE_WINDOW) return (ty == sh_special_code) && sh_special_done;
      return 1;
   endfunction

   task automatic shadow_put(int unsigned pos, logic [11:0] ty, logic [31:0] t);
      for (int i = sh_fill; i > pos; i--) begin
         sh_type[i] = sh_type[i-1];
         sh_time[i] = sh_time[i-1];
      end
      sh_type[pos] = ty;
      sh_time[pos] = t;
      sh_fill++;
   endtask

   task automatic shadow_take(int unsigned pos);
      for (int i = pos; i + 1 < sh_fill; i++) begin
         sh_type[i] = sh_type[i+1];
         sh_time[i] = sh_time[i+1];
      end
      sh_fill--;
   endtask

   task automatic shadow_insert(logic [11:0] ty, logic [31:0] t, logic [31:0] cnt,
                                output logic ovf);
      bit          special;
      int unsigned pos;
      special = (ty == sh_special_code);
      ovf = 0;
      if (cnt > HALF_RANGE) sh_special_done = 0;
      if (sh_fill >= DEPTH) begin
         ovf = 1;
         return;
      end
      if (sh_fill == 0 || (!special && precedes(t, sh_time[0], sh_type[0], cnt))) begin
         shadow_put(0, ty, t);
         sh_next_due = t;
         return;
      end
      pos = 0;
      while (pos + 1 < sh_fill &&
             (special || !precedes(t, sh_time[pos+1], sh_type[pos+1], cnt)))
         pos++;
      if (!special)
         while (pos + 1 < sh_fill && sh_time[pos+1] == t) pos++;
      shadow_put(pos + 1, ty, t);
   endtask

   task automatic apply_queue_op(queue_op_t op);
      queue_status_t r;
      int unsigned   idx;
      r = '{default: 0};
      case (op.opcode)
         OP_INS_DELAY:
            shadow_insert(op.event_type, op.current_count + op.time_value,
                          op.current_count, r.overflow);
         OP_INS_AT:
            shadow_insert(op.event_type, op.time_value, op.current_count, r.overflow);
         OP_POP:
            if (sh_fill > 0) begin
               r.popped_type = sh_type[0];
               if (sh_type[0] == sh_special_code) sh_special_done = 1;
               shadow_take(0);
               if (sh_fill > 0 && (sh_time[0] > op.current_count ||
                   (op.current_count - sh_time[0]) < HALF_RANGE))
                  sh_next_due = sh_time[0];
               else
                  sh_next_due = 0;
            end
         OP_REMOVE, OP_FIND: begin
            idx = sh_fill;
            for (int i = sh_fill - 1; i >= 0; i--)
               if (sh_type[i] == op.event_type) idx = i;
            if (idx < sh_fill) begin
               r.found = 1;
               r.found_time = sh_time[idx];
               if (op.opcode == OP_REMOVE) shadow_take(idx);
            end
         end
         default: ;
      endcase
      r.head_valid = sh_fill > 0;
      r.head_type = sh_fill > 0 ? sh_type[0] : 12'd0;
      r.head_time = sh_fill > 0 ? sh_time[0] : 32'd0;
      r.next_event_time = sh_next_due;
      r.occupancy = sh_fill[4:0];
      expected_status.push_back(r);
   endtask

   function automatic queue_op_t make_op(logic [2:0] opc, logic [11:0] ty,
                                         logic [31:0] tv, logic [31:0] cnt);
      queue_op_t o;
      o.opcode = opc;
      o.event_type = ty;
      o.time_value = tv;
      o.current_count = cnt;
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) apply_queue_op(pending_ops.pop_front());
         if (req_tvalid && !req_tready) begin
            // hold the transaction
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 0;
         end else if (drain_request || pending_ops.size() == 0) begin
            req_tvalid <= 0;
         end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(1, 7) - 1;
            req_tvalid <= 0;
         end else begin
            queue_op_t n;
            n = pending_ops[0];
            req_tvalid <= 1;
            req_tdata <= {1'b0, n.current_count, n.time_value, n.event_type, n.opcode};
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         recv_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            queue_status_t e;
            if (expected_status.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               failed = 1;
            end else begin
               e = expected_status.pop_front();
               if (rsp_tdata[0] !== e.head_valid) begin
                  $error("head_valid exp %0d got %0d", e.head_valid, rsp_tdata[0]);
                  failed = 1;
               end
               if (rsp_tdata[12:1] !== e.head_type) begin
                  $error("head_type exp %0h got %0h", e.head_type, rsp_tdata[12:1]);
                  failed = 1;
               end
               if (rsp_tdata[44:13] !== e.head_time) begin
                  $error("head_time exp %0h got %0h", e.head_time, rsp_tdata[44:13]);
                  failed = 1;
               end
               if (rsp_tdata[76:45] !== e.next_event_time) begin
                  $error("next_event_time exp %0h got %0h", e.next_event_time,
                         rsp_tdata[76:45]);
                  failed = 1;
               end
               if (rsp_tdata[88:77] !== e.popped_type) begin
                  $error("popped_type exp %0h got %0h", e.popped_type, rsp_tdata[88:77]);
                  failed = 1;
               end
               if (rsp_tdata[89] !== e.found) begin
                  $error("found exp %0d got %0d", e.found, rsp_tdata[89]);
                  failed = 1;
               end
               if (rsp_tdata[121:90] !== e.found_time) begin
                  $error("found_time exp %0h got %0h", e.found_time, rsp_tdata[121:90]);
                  failed = 1;
               end
               if (rsp_tdata[122] !== e.overflow) begin
                  $error("overflow exp %0d got %0d", e.overflow, rsp_tdata[122]);
                  failed = 1;
               end
               if (rsp_tdata[127:123] !== e.occupancy) begin
                  $error("occupancy exp %0d got %0d", e.occupancy, rsp_tdata[127:123]);
                  failed = 1;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 0;
         end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            recv_gap <= $urandom_range(1, 7) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_ops.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_special_code(logic [11:0] code);
      @(posedge clock);
      csr_wen <= 1;
      csr_wdata <= code;
      @(posedge clock);
      csr_wen <= 0;
      sh_special_code = code;
   endtask

   // mostly times near the count so ordering matters; some stale and far ones
   function automatic queue_op_t random_op(logic [31:0] cnt);
      int          sel;
      logic [2:0]  opc;
      logic [11:0] ty;
      logic [31:0] tv;
      sel = $urandom_range(0, 99);
      if (sel < 30) opc = OP_INS_DELAY;
      else if (sel < 50) opc = OP_INS_AT;
      else if (sel < 72) opc = OP_POP;
      else if (sel < 84) opc = OP_REMOVE;
      else if (sel < 97) opc = OP_FIND;
      else opc = 3'($urandom_range(5, 7));
      sel = $urandom_range(0, 9);
      if (sel < 2) ty = sh_special_code;
      else if (sel < 9) ty = 12'($urandom_range(0, 7));
      else ty = 12'($urandom);
      sel = $urandom_range(0, 9);
      if (opc == OP_INS_DELAY)
         tv = sel < 7 ? 32'($urandom_range(0, 64)) : $urandom;
      else if (sel < 4) tv = cnt + 32'($urandom_range(0, 64));
      else if (sel < 7) tv = cnt - 32'($urandom_range(1, 64));
      else if (sel < 8) tv = cnt - STALE_WINDOW - 32'($urandom_range(0, 3));
      else tv = $urandom;
      return make_op(opc, ty, tv, cnt);
   endfunction

   task automatic random_phase(int n, logic [31:0] base);
      logic [31:0] cnt;
      cnt = base;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) cnt = $urandom;
         else cnt = cnt + 32'($urandom_range(0, 20));
         pending_ops.push_back(random_op(cnt));
      end
   endtask

   initial begin
      failed = 0;
      quiet_mode = 0;
      drain_request = 0;
      timed_out = 0;
      csr_wen = 0;
      csr_wdata = '0;
      req_tvalid = 0;
      req_tdata = '0;
      rsp_tready = 0;
      sh_fill = 0;
      sh_special_done = 0;
      sh_next_due = 0;
      sh_special_code = 12'd32;
      for (int i = 0; i < DEPTH; i++) begin
         sh_type[i] = 0;
         sh_time[i] = 0;
      end
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty pop, fill beyond full, special handling, stale heads
      pending_ops.push_back(make_op(OP_POP, 12'd0, 32'd0, 32'd0));
      pending_ops.push_back(make_op(OP_FIND, 12'hFFF, 32'd0, 32'd0));
      pending_ops.push_back(make_op(OP_REMOVE, 12'd5, 32'd0, 32'd0));
      pending_ops.push_back(make_op(OP_INS_DELAY, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(OP_INS_AT, 12'd32, 32'd100, 32'd50));
      pending_ops.push_back(make_op(OP_INS_AT, 12'd1, 32'd60, 32'd50));
      pending_ops.push_back(make_op(OP_INS_AT, 12'd2, 32'd60, 32'd50));
      pending_ops.push_back(make_op(OP_INS_AT, 12'd3, 32'd10, 32'd50));
      pending_ops.push_back(make_op(OP_INS_AT, 12'd4, 32'h9000_0000, 32'd50));
      for (int i = 0; i < 12; i++)
         pending_ops.push_back(make_op(OP_INS_DELAY, 12'd1, 32'(i * 3), 32'd50));
      pending_ops.push_back(make_op(OP_FIND, 12'd1, 32'd0, 32'd50));
      pending_ops.push_back(make_op(OP_REMOVE, 12'd2, 32'd0, 32'd50));
      pending_ops.push_back(make_op(3'd7, 12'd0, 32'd0, 32'd50));
      for (int i = 0; i < 3; i++)
         pending_ops.push_back(make_op(OP_POP, 12'd0, 32'd0, 32'h8000_0001));
      wait_idle();

      // flush the queue before a new type code
      for (int i = 0; i < 17; i++)
         pending_ops.push_back(make_op(OP_POP, 12'd0, 32'd0, 32'd0));
      wait_idle();
      write_special_code(12'hFFF);
      random_phase(250, $urandom);
      // sender waits for every result midway, then resumes
      while (pending_ops.size() > 125) @(posedge clock);
      drain_request = 1;
      @(posedge clock);
      while (req_tvalid || expected_status.size() != 0) @(posedge clock);
      drain_request = 0;
      wait_idle();
      write_special_code(12'd0);
      random_phase(250, 32'h7FFF_FF00);
      wait_idle();
      write_special_code(12'd5);
      random_phase(250, 32'hFFFF_FF00);
      wait_idle();
      write_special_code(12'd32);
      quiet_mode = 1;
      random_phase(300, $urandom);
      wait_idle();
      repeat (20) @(posedge clock);

      if (failed)
         $display("Mismatches found");
      else
         $display("No mismatches found");
      $finish;
   end
endmodule
